// ===== rtl/lfr_pkg.sv =====
// lfr_pkg: transaction structs, state codes, reply tables and constants
// for lock_frame_responder
// no dependencies
package lfr_pkg;

    // input transaction: a received byte or a millisecond tick
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } item_t;

    // output transaction: one reply byte
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } reply_t;

    // deframer phases
    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_ID   = 5'b00100,
        PH_CMD  = 5'b01000,
        PH_DATA = 5'b10000
    } rx_phase_t;

    // reply sequencer states
    typedef enum logic [1:0] {
        EMIT_IDLE = 2'b01,
        EMIT_RUN  = 2'b10
    } emit_state_t;

    // item modes
    localparam logic ModeByte = 1'b0;

    // register addresses (word index, paddr[2])
    localparam logic RegInsert = 1'b0;
    localparam logic RegExit   = 1'b1;

    // framing constants
    localparam logic [7:0] StartByte   = 8'h00;
    localparam logic [7:0] LenOverhead = 8'd3;
    localparam logic [7:0] DataStart   = 8'h53;
    localparam logic [7:0] DataResume  = 8'h45;

    // reply entries
    localparam int         RomRow       = 15;
    localparam int         RomEntries   = 8;
    localparam logic [2:0] EntryBoot    = 3'd0;
    localparam logic [2:0] EntryResume  = 3'd1;
    localparam logic [2:0] EntryStart   = 3'd2;
    localparam logic [2:0] EntryChain   = 3'd3;
    localparam logic [2:0] EntryChainEnd = 3'd7;
    localparam logic [5:0] BootWait     = 6'd30;

    // wait in ticks per entry
    function automatic logic [5:0] reply_wait(input logic [2:0] entry);
        logic [5:0] w;
        unique case (entry)
            3'd0:    w = 6'd30;
            3'd1:    w = 6'd15;
            3'd2:    w = 6'd2;
            3'd3:    w = 6'd0;
            3'd4:    w = 6'd40;
            3'd5:    w = 6'd40;
            3'd6:    w = 6'd40;
            default: w = 6'd40;
        endcase
        return w;
    endfunction

    // stored byte count per entry
    function automatic logic [3:0] reply_len(input logic [2:0] entry);
        logic [3:0] n;
        unique case (entry)
            3'd3, 3'd4, 3'd5: n = 4'd7;
            default:          n = 4'd15;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/lock_frame_responder.sv =====
// lock_frame_responder: serial frame decoder with timed replies from a reply rom
// depends on lfr_pkg
//
//  channel   | signals                          | direction | transaction
//  ----------+----------------------------------+-----------+---------------------------
//  item      | item_valid, item_stall, item     | in        | rx byte or 1 ms tick
//  reply     | reply_valid, reply_stall, reply  | out       | one reply byte, last marked
//  config    | psel, penable, pwrite, paddr ... | in        | register write / read
//
// a byte transaction and a tick that fires nothing never raise item_stall
// a firing tick of an n-byte entry holds item_stall while the rom read port issues
//   its n bytes at one byte a cycle while the buffer has room; bytes then drain at one per cycle
//   while reply_stall is low; the rom port feeds the two-stage output buffer; reply_stall
//   pauses rom reads once both stages are full
// reset arms entry 0 with a 30 tick wait; no clearing pass is needed
module lock_frame_responder #(
    parameter int REPLY_BYTES = 15
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  lfr_pkg::item_t      item,
    output logic                reply_valid,
    input  logic                reply_stall,
    output lfr_pkg::reply_t     reply,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // longest emitted reply, capped by the rom row
    localparam int CapInt = (REPLY_BYTES < lfr_pkg::RomRow) ? REPLY_BYTES : lfr_pkg::RomRow;
    localparam logic [3:0] CapLen = 4'(CapInt);

    // reply rom: registered read, one byte per cycle while the output buffer has room
    localparam logic [7:0] ReplyRom [lfr_pkg::RomEntries][lfr_pkg::RomRow] = '{
        '{8'h80,8'h0D,8'h00,8'h45,8'h59,8'hB2,8'h11,8'h04,
          8'h00,8'h00,8'h6B,8'h98,8'h12,8'hFA,8'h2D},
        '{8'h80,8'h0D,8'h00,8'h45,8'h59,8'hB2,8'h12,8'h84,
          8'h00,8'h00,8'h00,8'hDC,8'h04,8'h65,8'h08},
        '{8'h80,8'h0D,8'h00,8'h53,8'h44,8'h13,8'h4A,8'h61,
          8'h07,8'h10,8'h10,8'h22,8'h08,8'h56,8'hD9},
        '{8'h80,8'h05,8'h00,8'h48,8'h30,8'h2C,8'hD1,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h80,8'h05,8'h00,8'h48,8'h50,8'h2A,8'hB7,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h80,8'h05,8'h00,8'h48,8'h60,8'h3A,8'h97,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h80,8'h0D,8'h00,8'h45,8'hA6,8'h7E,8'h82,8'h0A,
          8'h00,8'h00,8'h52,8'hF5,8'h3C,8'h13,8'h10},
        '{8'h80,8'h0D,8'h00,8'h45,8'hA6,8'h7E,8'hA3,8'h8A,
          8'h00,8'h00,8'hA5,8'hDD,8'hB5,8'h26,8'hD2}
    };

    // configuration registers
    logic [7:0] insert_code_reg;
    logic [7:0] exit_code_reg;

    // deframer state
    lfr_pkg::rx_phase_t rx_phase_reg, rx_phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] data_count_reg, data_count_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [7:0] frame_command_reg, frame_command_next;
    logic [7:0] first_data_reg, first_data_next;

    // reply scheduling state
    logic       reply_pending_reg, reply_pending_next;
    logic [5:0] wait_countdown_reg, wait_countdown_next;
    logic [2:0] reply_entry_reg, reply_entry_next;
    logic       chain_active_reg, chain_active_next;
    logic [2:0] chain_index_reg, chain_index_next;

    // reply sequencer and output buffer
    lfr_pkg::emit_state_t emit_state_reg;
    logic [2:0] emit_entry_reg;
    logic [3:0] emit_len_reg;
    logic [3:0] rd_idx_reg;
    logic       q_vld_reg;
    logic [7:0] q_byte_reg;
    logic       q_last_reg;
    logic       out_vld_reg;
    lfr_pkg::reply_t out_reg;

    logic       accept;
    logic       emit_start;
    logic [5:0] tick_count;
    logic [2:0] chain_step;
    logic       out_free;
    logic       issue;
    logic       issue_last;
    logic       cfg_write;

    assign accept     = item_valid && !item_stall;
    assign item_stall = (emit_state_reg != lfr_pkg::EMIT_IDLE);

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            lfr_pkg::RegInsert: prdata = {24'd0, insert_code_reg};
            default:            prdata = {24'd0, exit_code_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            insert_code_reg <= 8'd1;
            exit_code_reg   <= 8'd2;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                lfr_pkg::RegInsert: insert_code_reg <= pwdata[7:0];
                default:            exit_code_reg   <= pwdata[7:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // deframer and tick handling, one transaction per cycle while item_stall is low
    // ------------------------------------------------------------------
    always_comb
    begin
        rx_phase_next       = rx_phase_reg;
        bytes_left_next     = bytes_left_reg;
        data_count_next     = data_count_reg;
        running_xor_next    = running_xor_reg;
        frame_command_next  = frame_command_reg;
        first_data_next     = first_data_reg;
        reply_pending_next  = reply_pending_reg;
        wait_countdown_next = wait_countdown_reg;
        reply_entry_next    = reply_entry_reg;
        chain_active_next   = chain_active_reg;
        chain_index_next    = chain_index_reg;
        emit_start          = 1'b0;
        tick_count          = wait_countdown_reg;
        chain_step          = chain_index_reg + 3'd1;

        if (accept && item.mode == lfr_pkg::ModeByte)
        begin
            unique case (rx_phase_reg)
                lfr_pkg::PH_IDLE:
                begin
                    if (item.rx_byte == lfr_pkg::StartByte)
                        rx_phase_next = lfr_pkg::PH_LEN;
                end
                lfr_pkg::PH_LEN:
                begin
                    bytes_left_next  = item.rx_byte - lfr_pkg::LenOverhead;
                    running_xor_next = item.rx_byte;
                    data_count_next  = 8'd0;
                    rx_phase_next    = lfr_pkg::PH_ID;
                end
                lfr_pkg::PH_ID:
                begin
                    running_xor_next = running_xor_reg ^ item.rx_byte;
                    rx_phase_next    = lfr_pkg::PH_CMD;
                end
                lfr_pkg::PH_CMD:
                begin
                    frame_command_next = item.rx_byte;
                    running_xor_next   = running_xor_reg ^ item.rx_byte;
                    rx_phase_next      = lfr_pkg::PH_DATA;
                end
                lfr_pkg::PH_DATA:
                begin
                    if (data_count_reg < bytes_left_reg)
                    begin
                        running_xor_next = running_xor_reg ^ item.rx_byte;
                        if (data_count_reg == 8'd0)
                            first_data_next = item.rx_byte;
                        data_count_next = data_count_reg + 8'd1;
                    end
                    else
                    begin
                        // checksum byte closes the frame
                        rx_phase_next = lfr_pkg::PH_IDLE;
                        if (running_xor_reg == item.rx_byte)
                        begin
                            if (frame_command_reg == insert_code_reg)
                            begin
                                if (first_data_reg == lfr_pkg::DataStart)
                                begin
                                    reply_entry_next    = lfr_pkg::EntryStart;
                                    reply_pending_next  = 1'b1;
                                    wait_countdown_next =
                                        lfr_pkg::reply_wait(lfr_pkg::EntryStart);
                                end
                                else if (first_data_reg == lfr_pkg::DataResume)
                                begin
                                    reply_entry_next    = lfr_pkg::EntryResume;
                                    reply_pending_next  = 1'b1;
                                    wait_countdown_next =
                                        lfr_pkg::reply_wait(lfr_pkg::EntryResume);
                                end
                            end
                            else if (frame_command_reg == exit_code_reg)
                            begin
                                // exit command starts the chain at its first entry
                                chain_active_next   = 1'b1;
                                chain_index_next    = lfr_pkg::EntryChain;
                                reply_entry_next    = lfr_pkg::EntryChain;
                                reply_pending_next  = 1'b1;
                                wait_countdown_next =
                                    lfr_pkg::reply_wait(lfr_pkg::EntryChain);
                            end
                        end
                    end
                end
                default:
                begin
                    rx_phase_next = lfr_pkg::PH_IDLE;
                end
            endcase
        end
        else if (accept && reply_pending_reg)
        begin
            // tick: count down first, fire on reaching zero
            if (wait_countdown_reg != 6'd0)
                tick_count = wait_countdown_reg - 6'd1;
            wait_countdown_next = tick_count;
            if (tick_count == 6'd0)
            begin
                reply_pending_next = 1'b0;
                emit_start         = 1'b1;
                if (chain_active_reg)
                begin
                    chain_index_next = chain_step;
                    if (chain_step >= lfr_pkg::EntryChainEnd)
                        chain_active_next = 1'b0;
                    reply_entry_next    = chain_step;
                    reply_pending_next  = 1'b1;
                    wait_countdown_next = lfr_pkg::reply_wait(chain_step);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase_reg       <= lfr_pkg::PH_IDLE;
            bytes_left_reg     <= 8'd0;
            data_count_reg     <= 8'd0;
            running_xor_reg    <= 8'd0;
            frame_command_reg  <= 8'd0;
            first_data_reg     <= 8'd0;
            reply_pending_reg  <= 1'b1;
            wait_countdown_reg <= lfr_pkg::BootWait;
            reply_entry_reg    <= lfr_pkg::EntryBoot;
            chain_active_reg   <= 1'b0;
            chain_index_reg    <= 3'd0;
        end
        else
        begin
            rx_phase_reg       <= rx_phase_next;
            bytes_left_reg     <= bytes_left_next;
            data_count_reg     <= data_count_next;
            running_xor_reg    <= running_xor_next;
            frame_command_reg  <= frame_command_next;
            first_data_reg     <= first_data_next;
            reply_pending_reg  <= reply_pending_next;
            wait_countdown_reg <= wait_countdown_next;
            reply_entry_reg    <= reply_entry_next;
            chain_active_reg   <= chain_active_next;
            chain_index_reg    <= chain_index_next;
        end
    end

    // ------------------------------------------------------------------
    // reply sequencer: rom read stage feeding the output register
    // ------------------------------------------------------------------
    assign out_free   = !out_vld_reg || !reply_stall;
    assign issue      = (emit_state_reg == lfr_pkg::EMIT_RUN) && (!q_vld_reg || out_free);
    assign issue_last = (rd_idx_reg == emit_len_reg - 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_state_reg <= lfr_pkg::EMIT_IDLE;
            emit_entry_reg <= 3'd0;
            emit_len_reg   <= 4'd0;
            rd_idx_reg     <= 4'd0;
            q_vld_reg      <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            unique case (emit_state_reg)
                lfr_pkg::EMIT_IDLE:
                begin
                    if (emit_start)
                    begin
                        // latch the firing entry before the chain re-arms
                        emit_state_reg <= lfr_pkg::EMIT_RUN;
                        emit_entry_reg <= reply_entry_reg;
                        rd_idx_reg     <= 4'd0;
                        if (lfr_pkg::reply_len(reply_entry_reg) > CapLen)
                            emit_len_reg <= CapLen;
                        else
                            emit_len_reg <= lfr_pkg::reply_len(reply_entry_reg);
                    end
                end
                lfr_pkg::EMIT_RUN:
                begin
                    if (issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 4'd1;
                        if (issue_last)
                            emit_state_reg <= lfr_pkg::EMIT_IDLE;
                    end
                end
                default:
                begin
                    emit_state_reg <= lfr_pkg::EMIT_IDLE;
                end
            endcase

            if (issue)
                q_vld_reg <= 1'b1;
            else if (out_free)
                q_vld_reg <= 1'b0;

            if (out_free)
                out_vld_reg <= q_vld_reg;
        end
    end

    // rom read and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            q_byte_reg <= ReplyRom[emit_entry_reg][rd_idx_reg];
            q_last_reg <= issue_last;
        end
        if (out_free && q_vld_reg)
        begin
            out_reg.tx_byte <= q_byte_reg;
            out_reg.tx_last <= q_last_reg;
        end
    end

    assign reply_valid = out_vld_reg;
    assign reply       = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(issue && q_vld_reg && out_vld_reg && reply_stall))
        else $error("rom read issued into a full output buffer");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_last) |=> (emit_state_reg == lfr_pkg::EMIT_IDLE))
        else $error("sequencer kept running after the last byte");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_state_reg == lfr_pkg::EMIT_RUN) |-> (rd_idx_reg < emit_len_reg))
        else $error("rom read index past the reply length");

    a_chain_range: assert property (@(posedge clk) disable iff (!rst_n)
        chain_active_reg |-> (chain_index_reg >= lfr_pkg::EntryChain &&
                              chain_index_reg < lfr_pkg::EntryChainEnd))
        else $error("exit chain index out of range while active");

    a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_start |-> (emit_state_reg == lfr_pkg::EMIT_IDLE))
        else $error("reply fired while a reply was still being read");

endmodule
